>>> rtl/html_table_cell_flattener_top_macros.svh
// Assertion macros used by the checker file of the cell flattener.
`ifndef HTML_TABLE_CELL_FLATTENER_TOP_MACROS_SVH
`define HTML_TABLE_CELL_FLATTENER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/htcf_pkg.sv
// ---------------------------------------------------------------------------
// HTML table cell flattener package
// Character codes, tag name patterns and the token passed from front to back.
// ---------------------------------------------------------------------------
package htcf_pkg;

  localparam int unsigned HTCF_QUEUE_DEPTH = 2;

  localparam logic [7:0] ASCII_LT     = 8'h3C;
  localparam logic [7:0] ASCII_GT     = 8'h3E;
  localparam logic [7:0] ASCII_SQUOTE = 8'h27;
  localparam logic [7:0] ASCII_DQUOTE = 8'h22;
  localparam logic [7:0] ASCII_SEMI   = 8'h3B;
  localparam logic [7:0] ASCII_NL     = 8'h0A;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_TAB    = 8'h09;
  localparam logic [7:0] ASCII_CR     = 8'h0D;
  localparam logic [7:0] ASCII_LOW_A  = 8'h61;
  localparam logic [7:0] ASCII_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Upper-cased tag names, packed as they shift in from the low end.
  localparam logic [23:0] NAME_TD     = 24'h005444;
  localparam logic [23:0] NAME_END_TD = 24'h2F5444;
  localparam logic [23:0] NAME_END_TR = 24'h2F5452;

  // Byte classes that the parser acts on.
  typedef enum logic [2:0] {
    TOK_OTHER,
    TOK_LT,
    TOK_GT,
    TOK_SQUOTE,
    TOK_DQUOTE,
    TOK_SPACE
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] raw;    // byte as received
    logic [7:0] upper;  // byte with lower-case letters upper-cased
  } tok_t;

endpackage

>>> rtl/htcf_front.sv
// ---------------------------------------------------------------------------
// Front end
// Accepts input items and classifies each byte into a token for the queue.
// ---------------------------------------------------------------------------
module htcf_front
  import htcf_pkg::*;
(
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output tok_t       q_tok_o
);

  logic is_space;
  logic is_lower;

  // The front takes an item whenever the queue has room.
  assign s_ready_o = q_ready_i;
  assign q_push_o  = s_valid_i && q_ready_i;

  // C-locale whitespace: space, tab, newline, vertical tab, form feed, return.
  assign is_space = (s_byte_i == ASCII_SPACE) ||
                    ((s_byte_i >= ASCII_TAB) && (s_byte_i <= ASCII_CR));
  assign is_lower = (s_byte_i >= ASCII_LOW_A) && (s_byte_i <= ASCII_LOW_Z);

  // Classify the byte.
  always_comb begin
    q_tok_o.raw   = s_byte_i;
    q_tok_o.upper = is_lower ? (s_byte_i - CASE_OFFSET) : s_byte_i;
    if (s_byte_i == ASCII_LT) begin
      q_tok_o.kind = TOK_LT;
    end else if (s_byte_i == ASCII_GT) begin
      q_tok_o.kind = TOK_GT;
    end else if (s_byte_i == ASCII_SQUOTE) begin
      q_tok_o.kind = TOK_SQUOTE;
    end else if (s_byte_i == ASCII_DQUOTE) begin
      q_tok_o.kind = TOK_DQUOTE;
    end else if (is_space) begin
      q_tok_o.kind = TOK_SPACE;
    end else begin
      q_tok_o.kind = TOK_OTHER;
    end
  end

endmodule

>>> rtl/htcf_queue.sv
// ---------------------------------------------------------------------------
// Token queue
// Short first-in first-out queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module htcf_queue
  import htcf_pkg::*;
#(
  parameter int unsigned Depth = HTCF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t tok_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output tok_t tok_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written only; no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

>>> rtl/htcf_back.sv
// ---------------------------------------------------------------------------
// Back end
// Runs the tag parser on queued tokens and drives the output register.
// ---------------------------------------------------------------------------
module htcf_back
  import htcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  tok_t       q_tok_i,
  output logic       q_pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o
);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_NAME,
    MODE_ATTR
  } mode_e;

  typedef enum logic [1:0] {
    QUOTE_NONE,
    QUOTE_SINGLE,
    QUOTE_DOUBLE
  } quote_e;

  mode_e       mode_q, mode_d;
  quote_e      quote_q, quote_d;
  logic [2:0]  name_len_q, name_len_d;
  logic [23:0] name_q, name_d;
  logic        in_cell_q, in_cell_d;
  logic        after_space_q, after_space_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;

  logic        emit;
  logic [7:0]  emit_byte;
  logic        close_tag;

  // A token is taken when the output register is free or being emptied.
  assign q_pop_o   = q_valid_i && (!out_valid_q || m_ready_i);
  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;

  // Parser step for the token at the head of the queue.
  always_comb begin
    mode_d        = mode_q;
    quote_d       = quote_q;
    name_len_d    = name_len_q;
    name_d        = name_q;
    in_cell_d     = in_cell_q;
    after_space_d = after_space_q;
    emit          = 1'b0;
    emit_byte     = q_tok_i.raw;
    close_tag     = 1'b0;

    if (q_pop_o) begin
      case (mode_q)
        MODE_NAME: begin
          if (q_tok_i.kind == TOK_GT) begin
            close_tag = 1'b1;
          end else if (q_tok_i.kind == TOK_SPACE) begin
            mode_d = MODE_ATTR;
          end else begin
            if (name_len_q < 3'd3) begin
              name_d = {name_q[15:0], q_tok_i.upper};
            end
            if (name_len_q < 3'd4) begin
              name_len_d = name_len_q + 3'd1;
            end
          end
        end
        MODE_ATTR: begin
          if (q_tok_i.kind == TOK_SQUOTE) begin
            if (quote_q == QUOTE_SINGLE) begin
              quote_d = QUOTE_NONE;
            end else if (quote_q == QUOTE_NONE) begin
              quote_d = QUOTE_SINGLE;
            end
          end else if (q_tok_i.kind == TOK_DQUOTE) begin
            if (quote_q == QUOTE_DOUBLE) begin
              quote_d = QUOTE_NONE;
            end else if (quote_q == QUOTE_NONE) begin
              quote_d = QUOTE_DOUBLE;
            end
          end else if (q_tok_i.kind == TOK_GT && quote_q == QUOTE_NONE) begin
            close_tag = 1'b1;
          end
        end
        default: begin
          // Text mode.
          if (q_tok_i.kind == TOK_LT) begin
            mode_d     = MODE_NAME;
            quote_d    = QUOTE_NONE;
            name_len_d = 3'd0;
            name_d     = '0;
          end else if (in_cell_q) begin
            if (q_tok_i.kind == TOK_SPACE) begin
              if (!after_space_q) begin
                after_space_d = 1'b1;
                emit          = 1'b1;
                emit_byte     = ASCII_SPACE;
              end
            end else begin
              after_space_d = 1'b0;
              emit          = 1'b1;
            end
          end
        end
      endcase

      // Act on the finished tag name.
      if (close_tag) begin
        mode_d = MODE_TEXT;
        if (name_len_q == 3'd2 && name_q == NAME_TD) begin
          in_cell_d = 1'b1;
        end else if (name_len_q == 3'd3 && name_q == NAME_END_TD) begin
          in_cell_d     = 1'b0;
          after_space_d = 1'b0;
          emit          = 1'b1;
          emit_byte     = ASCII_SEMI;
        end else if (name_len_q == 3'd3 && name_q == NAME_END_TR) begin
          emit      = 1'b1;
          emit_byte = ASCII_NL;
        end
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_TEXT;
      quote_q       <= QUOTE_NONE;
      name_len_q    <= 3'd0;
      name_q        <= '0;
      in_cell_q     <= 1'b0;
      after_space_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
    end else begin
      mode_q        <= mode_d;
      quote_q       <= quote_d;
      name_len_q    <= name_len_d;
      name_q        <= name_d;
      in_cell_q     <= in_cell_d;
      after_space_q <= after_space_d;
      out_valid_q   <= out_valid_d;
      out_byte_q    <= out_byte_d;
    end
  end

endmodule

>>> rtl/html_table_cell_flattener_top.sv
// ---------------------------------------------------------------------------
// HTML table cell flattener
// Turns an HTML byte stream into cell text, ';' per cell and a newline per row.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream takes one HTML byte per item on s_axis_tdata_i. The
//   master stream gives zero or one byte per input item on m_axis_tdata_o:
//   echoed cell text, one space per run of whitespace, ';' at the end of a
//   cell and a newline at the end of a row.
//   Throughput is one item per cycle in both directions while the receiver
//   does not stall. An accepted item is written into the token queue at its
//   accepting edge; the parser takes it from the queue head once the output
//   register is free or being emptied, and registers its byte, if any, on m_axis.
//   Reset clears the queue, the parser state and the output register; the
//   block comes out of reset in text mode, outside any cell.
//   When the receiver stalls, the output register holds its byte, the parser
//   stops, and the token queue fills; once it is full s_axis_tready_o drops.
// ---------------------------------------------------------------------------
module html_table_cell_flattener_top
  import htcf_pkg::*;
#(
  parameter int unsigned QueueDepth = HTCF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] out_byte
);

  logic q_ready;
  logic q_push;
  tok_t q_tok_in;
  logic q_valid;
  logic q_pop;
  tok_t q_tok_out;

  htcf_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_tok_o   (q_tok_in)
  );

  htcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .tok_i   (q_tok_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .tok_o   (q_tok_out)
  );

  htcf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_tok_i   (q_tok_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_byte_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/htcf_checker.sv
// ---------------------------------------------------------------------------
// Port checker
// Watches the top level's output stream for protocol and content slips.
// ---------------------------------------------------------------------------
`include "html_table_cell_flattener_top_macros.svh"

module htcf_checker
  import htcf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic out_stalled;
  logic out_is_lt;
  logic out_is_ctrl_space;

  assign out_stalled       = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_is_lt         = (m_axis_tdata_o == ASCII_LT);
  assign out_is_ctrl_space = (m_axis_tdata_o >= ASCII_TAB) && (m_axis_tdata_o <= ASCII_CR) &&
                             (m_axis_tdata_o != ASCII_NL);

  // A stalled item stays offered.
  `HTCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, m_axis_tvalid_o, "output dropped")

  // A stalled item keeps its byte.
  `HTCF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stalled, $stable(m_axis_tdata_o), "data moved")

  // A '<' is never echoed; in text it opens a tag.
  `HTCF_ASSERT_NOW(a_no_lt, clk_i, rst_ni, m_axis_tvalid_o, !out_is_lt, "tag opener echoed")

  // Whitespace inside cells is collapsed to a plain space.
  `HTCF_ASSERT_NOW(a_ws_collapsed, clk_i, rst_ni, m_axis_tvalid_o, !out_is_ctrl_space, "raw blank")

endmodule

bind html_table_cell_flattener_top htcf_checker u_checker (.*);
